// File: rtl/rsi_pkg.sv
// Shared types and constants for the relative strength index block.
// Depends on nothing; used by rsi_step and relative_strength_index.
package rsi_pkg;

    // Period register
    localparam int              PERIOD_BITS  = 10;
    localparam logic [9:0]      PERIOD_RESET = 10'd14;
    localparam logic [9:0]      PERIOD_MIN   = 10'd2;

    // RSI scale: 100 with 16 fraction bits
    localparam int              RSI_BITS       = 23;
    localparam logic [22:0]     RSI_SCALE      = 23'd6553600;
    localparam int              SCALE_IDX_BITS = 5;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_RATIO = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    // How the averages are updated for the current beat
    typedef enum logic [2:0] {
        M_WARM   = 3'b001,
        M_FIRST  = 3'b010,
        M_SMOOTH = 3'b100
    } t_mode;

    // Control of the shared shift-subtract unit
    typedef struct packed {
        logic clr;
        logic run;
        logic dbl;
    } t_step_ctl;

endpackage

// File: rtl/rsi_step.sv
// Shared shift-subtract step unit: one restoring division step per cycle.
// Depends on rsi_pkg (t_step_ctl).
module rsi_step #(
    parameter int W  = 49,
    parameter int QW = 48
) (
    input  logic                  i_clk,
    input  rsi_pkg::t_step_ctl    i_ctl,
    input  logic [W-1:0]          i_addend,
    input  logic [W-1:0]          i_divisor,
    output logic [QW-1:0]         o_quot
);

    logic [W-1:0]  r_rem,  n_rem;
    logic [QW-1:0] r_quot, n_quot;
    logic [W:0]    sum;
    logic [W:0]    diff;
    logic          ge;

    // rem' = (dbl ? 2*rem : rem) + addend, then one compare/subtract
    always_comb begin
        sum    = (i_ctl.dbl ? {r_rem, 1'b0} : {1'b0, r_rem}) + {1'b0, i_addend};
        diff   = sum - {1'b0, i_divisor};
        ge     = (sum >= {1'b0, i_divisor});
        n_rem  = r_rem;
        n_quot = r_quot;
        if (i_ctl.clr) begin
            n_rem  = '0;
            n_quot = '0;
        end else if (i_ctl.run) begin
            n_rem  = ge ? diff[W-1:0] : sum[W-1:0];
            n_quot = (i_ctl.dbl ? {r_quot[QW-2:0], 1'b0} : r_quot) + QW'(ge);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

// File: rtl/relative_strength_index.sv
// Relative strength index with Wilder smoothing, top level and sequencer.
// Depends on rsi_pkg and rsi_step.
//
// One price beat in, one result beat out. A warm-up beat (fewer than period
// prices seen) updates the sums without a division. For the period-th beat
// and every later one both averages are divided by the period on the shared
// shift-subtract unit, one quotient bit per cycle, and the scaled ratio
// 100*2^16*gain/(gain+loss) takes 46 steps on the same unit. When gain+loss
// is zero the ratio is skipped. The price input is not ready while a beat is
// in work; the next price is taken while the previous result still waits in
// the output register.
// A period write of 0 or 1 acts as 2. A zero gain+loss gives RSI 0 with
// o_no_movement set. Warm-up sums saturate at 2^ACC_BITS - 1.
module relative_strength_index #(
    parameter int PRICE_BITS = 32,
    parameter int ACC_BITS   = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [rsi_pkg::PERIOD_BITS-1:0] i_cfg_data,
    // price channel
    input  logic                          i_price_valid,
    output logic                          o_price_ready,
    input  logic [PRICE_BITS-1:0]         i_price,
    // result channel
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic                          o_ready_res,
    output logic [rsi_pkg::RSI_BITS-1:0]  o_rsi_value,
    output logic                          o_no_movement
);

    localparam int AVG_W = (ACC_BITS > PRICE_BITS) ? ACC_BITS : PRICE_BITS;
    localparam int W     = AVG_W + 1;
    localparam int CNT_W = $clog2(AVG_W);
    localparam logic [W-1:0] ACC_MAX = W'({ACC_BITS{1'b1}});

    // state and control registers
    rsi_pkg::t_state               r_state,  n_state;
    logic [rsi_pkg::PERIOD_BITS-1:0] r_period, n_period;
    logic [PRICE_BITS-1:0]         r_last_price, n_last_price;
    logic [rsi_pkg::PERIOD_BITS-1:0] r_count, n_count;
    logic [AVG_W-1:0]              r_gain, n_gain;
    logic [AVG_W-1:0]              r_loss, n_loss;
    logic                          r_out_valid, n_out_valid;

    // payload registers
    logic [AVG_W-1:0]              r_rise, n_rise;
    logic [AVG_W-1:0]              r_fall, n_fall;
    rsi_pkg::t_mode                r_mode, n_mode;
    logic                          r_add_en, n_add_en;
    logic [rsi_pkg::PERIOD_BITS-1:0] r_p, n_p;
    logic                          r_sel, n_sel;
    logic                          r_neg, n_neg;
    logic [AVG_W-1:0]              r_dvd, n_dvd;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic                          r_phase, n_phase;
    logic [W-1:0]                  r_den, n_den;
    logic                          r_res_ready, n_res_ready;
    logic                          r_res_zero, n_res_zero;
    logic                          r_o_ready_res, n_o_ready_res;
    logic [rsi_pkg::RSI_BITS-1:0]  r_o_rsi, n_o_rsi;
    logic                          r_o_nomove, n_o_nomove;

    // datapath helpers
    logic [rsi_pkg::PERIOD_BITS-1:0] p_eff;
    logic [rsi_pkg::PERIOD_BITS:0] size;
    logic [AVG_W-1:0]              price_ext, last_ext;
    logic [AVG_W-1:0]              avg_cur, mv_cur;
    logic [W-1:0]                  sat_sum;
    logic [AVG_W-1:0]              sat_val;
    logic [W-1:0]                  den_sum;
    logic [AVG_W-1:0]              quot_avg;
    logic                          price_beat;

    // shared unit hookup
    rsi_pkg::t_step_ctl            step_ctl;
    logic [W-1:0]                  step_add;
    logic [W-1:0]                  step_div;
    logic [AVG_W-1:0]              step_quot;

    rsi_step #(
        .W  (W),
        .QW (AVG_W)
    ) u_step (
        .i_clk     (i_clk),
        .i_ctl     (step_ctl),
        .i_addend  (step_add),
        .i_divisor (step_div),
        .o_quot    (step_quot)
    );

    assign price_beat = i_price_valid && o_price_ready;
    assign p_eff      = (r_period < rsi_pkg::PERIOD_MIN) ? rsi_pkg::PERIOD_MIN : r_period;
    assign size       = {1'b0, r_count} + 11'd1;
    assign price_ext  = AVG_W'(i_price);
    assign last_ext   = AVG_W'(r_last_price);
    assign avg_cur    = r_sel ? r_loss : r_gain;
    assign mv_cur     = r_sel ? r_fall : r_rise;
    assign sat_sum    = {1'b0, avg_cur} + {1'b0, mv_cur};
    assign sat_val    = (sat_sum > ACC_MAX) ? ACC_MAX[AVG_W-1:0] : sat_sum[AVG_W-1:0];
    assign den_sum    = {1'b0, r_gain} + {1'b0, r_loss};
    assign quot_avg   = step_quot;

    // step unit operands: divide by period, or scaled ratio gain/(gain+loss)
    always_comb begin
        step_ctl.clr = 1'b0;
        step_ctl.run = 1'b0;
        step_ctl.dbl = 1'b0;
        step_add     = '0;
        step_div     = r_den;
        case (r_state)
            rsi_pkg::S_PREP: begin
                step_ctl.clr = (r_mode != rsi_pkg::M_WARM);
            end
            rsi_pkg::S_SUM: begin
                step_ctl.clr = 1'b1;
            end
            rsi_pkg::S_DIV: begin
                step_ctl.run = 1'b1;
                step_ctl.dbl = 1'b1;
                step_add     = W'(r_dvd[AVG_W-1]);
                step_div     = W'(r_p);
            end
            rsi_pkg::S_RATIO: begin
                step_ctl.run = 1'b1;
                step_ctl.dbl = !r_phase;
                if (r_phase && rsi_pkg::RSI_SCALE[r_cnt[rsi_pkg::SCALE_IDX_BITS-1:0]]) begin
                    step_add = {1'b0, r_gain};
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_period      = r_period;
        n_last_price  = r_last_price;
        n_count       = r_count;
        n_gain        = r_gain;
        n_loss        = r_loss;
        n_out_valid   = r_out_valid && !i_res_ready;
        n_rise        = r_rise;
        n_fall        = r_fall;
        n_mode        = r_mode;
        n_add_en      = r_add_en;
        n_p           = r_p;
        n_sel         = r_sel;
        n_neg         = r_neg;
        n_dvd         = r_dvd;
        n_cnt         = r_cnt;
        n_phase       = r_phase;
        n_den         = r_den;
        n_res_ready   = r_res_ready;
        n_res_zero    = r_res_zero;
        n_o_ready_res = r_o_ready_res;
        n_o_rsi       = r_o_rsi;
        n_o_nomove    = r_o_nomove;

        if (i_cfg_we) begin
            n_period = i_cfg_data;
        end

        case (r_state)
            rsi_pkg::S_IDLE: begin
                if (price_beat) begin
                    n_rise       = (price_ext > last_ext) ? price_ext - last_ext : '0;
                    n_fall       = (price_ext > last_ext) ? '0 : last_ext - price_ext;
                    n_last_price = i_price;
                    n_p          = p_eff;
                    n_add_en     = (size > 11'd1);
                    n_sel        = 1'b0;
                    n_res_zero   = 1'b0;
                    if (size < {1'b0, p_eff}) begin
                        n_mode      = rsi_pkg::M_WARM;
                        n_count     = size[rsi_pkg::PERIOD_BITS-1:0];
                        n_res_ready = 1'b0;
                    end else if (size == {1'b0, p_eff}) begin
                        n_mode      = rsi_pkg::M_FIRST;
                        n_count     = size[rsi_pkg::PERIOD_BITS-1:0];
                        n_res_ready = 1'b1;
                    end else begin
                        n_mode      = rsi_pkg::M_SMOOTH;
                        n_res_ready = 1'b1;
                    end
                    n_state = rsi_pkg::S_PREP;
                end
            end
            rsi_pkg::S_PREP: begin
                n_cnt = CNT_W'(AVG_W - 1);
                case (r_mode)
                    rsi_pkg::M_WARM: begin
                        if (r_add_en) begin
                            if (r_sel) n_loss = sat_val;
                            else       n_gain = sat_val;
                        end
                        n_sel   = 1'b1;
                        n_state = r_sel ? rsi_pkg::S_FIN : rsi_pkg::S_PREP;
                    end
                    rsi_pkg::M_FIRST: begin
                        n_dvd   = sat_val;
                        n_state = rsi_pkg::S_DIV;
                    end
                    rsi_pkg::M_SMOOTH: begin
                        n_neg   = (mv_cur < avg_cur);
                        n_dvd   = (mv_cur < avg_cur) ? avg_cur - mv_cur : mv_cur - avg_cur;
                        n_state = rsi_pkg::S_DIV;
                    end
                    default: begin
                        n_state = rsi_pkg::S_IDLE;
                    end
                endcase
            end
            rsi_pkg::S_DIV: begin
                n_dvd = {r_dvd[AVG_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = rsi_pkg::S_APPLY;
                end
            end
            rsi_pkg::S_APPLY: begin
                // new average from the quotient just finished
                if (r_mode == rsi_pkg::M_FIRST) begin
                    if (r_sel) n_loss = quot_avg;
                    else       n_gain = quot_avg;
                end else begin
                    if (r_sel) n_loss = r_neg ? avg_cur - quot_avg : avg_cur + quot_avg;
                    else       n_gain = r_neg ? avg_cur - quot_avg : avg_cur + quot_avg;
                end
                n_sel   = 1'b1;
                n_state = r_sel ? rsi_pkg::S_SUM : rsi_pkg::S_PREP;
            end
            rsi_pkg::S_SUM: begin
                n_den   = den_sum;
                n_cnt   = CNT_W'(rsi_pkg::RSI_BITS - 1);
                n_phase = 1'b0;
                if (den_sum == '0) begin
                    n_res_zero = 1'b1;
                    n_state    = rsi_pkg::S_FIN;
                end else begin
                    n_state = rsi_pkg::S_RATIO;
                end
            end
            rsi_pkg::S_RATIO: begin
                // double step then add step, once per bit of the scale
                n_phase = !r_phase;
                if (r_phase) begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        n_state = rsi_pkg::S_FIN;
                    end
                end
            end
            rsi_pkg::S_FIN: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid   = 1'b1;
                    n_o_ready_res = r_res_ready;
                    n_o_nomove    = r_res_ready && r_res_zero;
                    n_o_rsi       = (r_res_ready && !r_res_zero) ?
                                    step_quot[rsi_pkg::RSI_BITS-1:0] : '0;
                    n_state       = rsi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsi_pkg::S_IDLE;
            end
        endcase
    end

    // control and model state, synchronous reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rsi_pkg::S_IDLE;
            r_period     <= rsi_pkg::PERIOD_RESET;
            r_last_price <= '0;
            r_count      <= '0;
            r_gain       <= '0;
            r_loss       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_period     <= n_period;
            r_last_price <= n_last_price;
            r_count      <= n_count;
            r_gain       <= n_gain;
            r_loss       <= n_loss;
            r_out_valid  <= n_out_valid;
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_rise        <= n_rise;
        r_fall        <= n_fall;
        r_mode        <= n_mode;
        r_add_en      <= n_add_en;
        r_p           <= n_p;
        r_sel         <= n_sel;
        r_neg         <= n_neg;
        r_dvd         <= n_dvd;
        r_cnt         <= n_cnt;
        r_phase       <= n_phase;
        r_den         <= n_den;
        r_res_ready   <= n_res_ready;
        r_res_zero    <= n_res_zero;
        r_o_ready_res <= n_o_ready_res;
        r_o_rsi       <= n_o_rsi;
        r_o_nomove    <= n_o_nomove;
    end

    assign o_price_ready = (r_state == rsi_pkg::S_IDLE);
    assign o_res_valid   = r_out_valid;
    assign o_ready_res   = r_o_ready_res;
    assign o_rsi_value   = r_o_rsi;
    assign o_no_movement = r_o_nomove;

    // a finished beat waits while the output register is still occupied
    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsi_pkg::S_FIN) && r_out_valid && !i_res_ready
        |=> (r_state == rsi_pkg::S_FIN))
        else $error("finished beat overwrote a pending result");

    // a result beat before warm-up ends carries all zero fields
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_ready_res |-> (o_rsi_value == '0) && !o_no_movement)
        else $error("non-ready result with nonzero fields");

    // RSI never exceeds 100
    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_rsi_value <= rsi_pkg::RSI_SCALE))
        else $error("RSI above full scale");

    // no movement forces a zero RSI
    a_nomove_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_no_movement |-> (o_rsi_value == '0) && o_ready_res)
        else $error("no-movement result with nonzero RSI");

    // a price beat always starts the sequencer
    a_beat_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        price_beat |=> (r_state == rsi_pkg::S_PREP))
        else $error("price beat did not start the sequencer");

endmodule
